[design/sapq_pkg.sv]
package sapq_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CMD_W        = 1;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned HELD_W       = 6;
  localparam int unsigned OUT_TDATA_W  = ((DATA_W + HELD_W + 7) / 8) * 8;
  localparam int unsigned CAPACITY_DEF = 32;

  localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                take;
    logic [STATUS_W-1:0] status;
    logic                ins_begin;
    logic                ins_shift;
    logic                ins_place;
    logic                rem_begin;
    logic                rem_head;
    logic                rem_shift;
    logic                emit;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic less;
    logic ptr_low;
    logic more;
    logic out_free;
  } dp_sts_t;

endpackage

[design/sapq_ram.sv]
module sapq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/sapq_controller.sv]
module sapq_controller import sapq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  logic [CMD_W-1:0] item_cmd_i,
  output logic             item_ready_o,
  input  dp_sts_t          sts_i,
  output ctl_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_PLACE,
    ST_REM_HEAD,
    ST_REM_SHIFT,
    ST_FIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.status = STATUS_OK;
    item_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          cmd_o.take = 1'b1;
          if (item_cmd_i == CMD_INSERT) begin
            if (sts_i.full) begin
              cmd_o.status = STATUS_FULL;
              state_d      = ST_FIN;
            end else begin
              cmd_o.ins_begin = 1'b1;
              state_d         = sts_i.empty ? ST_INS_PLACE : ST_INS_CMP;
            end
          end else begin
            if (sts_i.empty) begin
              cmd_o.status = STATUS_EMPTY;
              state_d      = ST_FIN;
            end else begin
              cmd_o.rem_begin = 1'b1;
              state_d         = ST_REM_HEAD;
            end
          end
        end
      end
      ST_INS_CMP: begin
        // Move larger entries up one place until the new value fits.
        if (sts_i.less) begin
          cmd_o.ins_shift = 1'b1;
          if (sts_i.ptr_low) begin
            state_d = ST_INS_PLACE;
          end
        end else begin
          cmd_o.ins_place = 1'b1;
          state_d         = ST_FIN;
        end
      end
      ST_INS_PLACE: begin
        cmd_o.ins_place = 1'b1;
        state_d         = ST_FIN;
      end
      ST_REM_HEAD: begin
        cmd_o.rem_head = 1'b1;
        state_d        = sts_i.more ? ST_REM_SHIFT : ST_FIN;
      end
      ST_REM_SHIFT: begin
        cmd_o.rem_shift = 1'b1;
        if (!sts_i.more) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/sapq_datapath.sv]
module sapq_datapath import sapq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [DATA_W-1:0]   value_i,
  input  ctl_cmd_t            cmd_i,
  output dp_sts_t             sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [DATA_W-1:0]   out_value_o,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [HELD_W-1:0]   out_held_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);

  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        ptr_q, ptr_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic [DATA_W-1:0]    res_value_q, res_value_d;
  logic [STATUS_W-1:0]  res_status_q, res_status_d;
  logic                 out_valid_q, out_valid_d;
  logic [DATA_W-1:0]    out_value_q, out_value_d;
  logic [STATUS_W-1:0]  out_status_q, out_status_d;
  logic [HELD_W-1:0]    out_held_q, out_held_d;

  logic [CW-1:0]        count_dec, ptr_dec, ptr_dec2, ptr_inc;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [DATA_W-1:0]    ram_wdata, ram_rdata;

  sapq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign count_dec = count_q - CW'(1);
  assign ptr_dec   = ptr_q - CW'(1);
  assign ptr_dec2  = ptr_q - CW'(2);
  assign ptr_inc   = ptr_q + CW'(1);

  assign sts_o.full     = (count_q == CW'(CAPACITY));
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.less     = (val_q < $signed(ram_rdata));
  assign sts_o.ptr_low  = (ptr_q == CW'(1));
  assign sts_o.more     = (ptr_q < count_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    count_d      = count_q;
    ptr_d        = ptr_q;
    val_d        = val_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_held_d   = out_held_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    ram_we       = 1'b0;
    ram_waddr    = ptr_q[AW-1:0];
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = ptr_q[AW-1:0];

    if (cmd_i.take) begin
      val_d        = value_i;
      res_value_d  = '0;
      res_status_d = cmd_i.status;
    end

    if (cmd_i.ins_begin) begin
      ptr_d = count_q;
      if (count_q != '0) begin
        ram_re    = 1'b1;
        ram_raddr = count_dec[AW-1:0];
      end
    end

    // The stored entry just read is larger: it moves up into the hole.
    if (cmd_i.ins_shift) begin
      ram_we    = 1'b1;
      ram_waddr = ptr_q[AW-1:0];
      ram_wdata = ram_rdata;
      ptr_d     = ptr_dec;
      if (ptr_q != CW'(1)) begin
        ram_re    = 1'b1;
        ram_raddr = ptr_dec2[AW-1:0];
      end
    end

    if (cmd_i.ins_place) begin
      ram_we    = 1'b1;
      ram_waddr = ptr_q[AW-1:0];
      ram_wdata = val_q;
      count_d   = count_q + CW'(1);
    end

    if (cmd_i.rem_begin) begin
      ram_re    = 1'b1;
      ram_raddr = '0;
      ptr_d     = CW'(1);
    end

    if (cmd_i.rem_head) begin
      res_value_d = ram_rdata;
    end

    // The entry read in the previous cycle moves down by one place.
    if (cmd_i.rem_shift) begin
      ram_we    = 1'b1;
      ram_waddr = ptr_dec2[AW-1:0];
      ram_wdata = ram_rdata;
    end

    if (cmd_i.rem_head || cmd_i.rem_shift) begin
      if (ptr_q < count_q) begin
        ram_re    = 1'b1;
        ram_raddr = ptr_q[AW-1:0];
        ptr_d     = ptr_inc;
      end else begin
        count_d = count_dec;
      end
    end

    if (cmd_i.emit) begin
      out_valid_d  = 1'b1;
      out_value_d  = res_value_q;
      out_status_d = res_status_q;
      out_held_d   = HELD_W'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    val_q        <= val_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_held_q   <= out_held_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;
  assign out_held_o   = out_held_q;

endmodule

[design/sorted_array_priority_queue.sv]
// Minimum priority queue of signed 32-bit values, kept in ascending order
// in a single-port-write, registered-read RAM of CAPACITY entries.
// Input channel (s_*): s_tuser_i is the command (0 insert, 1 remove) and
// s_tdata_i the value to insert. Output channel (m_*): one item per input
// item, carrying the removed value, the entry count and the status.
// Equal values leave in the order they arrived.
// One item is worked on at a time. The RAM moves one entry per cycle, so
// an insert takes longer the more stored entries are larger than the value,
// and a remove takes longer the more entries are held; a refused insert or
// an empty remove moves no entries and goes straight to the result.
// The next item is accepted in the cycle after the result is loaded.
// The result sits in an output register; the next item is accepted while
// it waits. If the receiver still holds off when the following result is
// ready, the block waits and does not accept further items.
// Reset empties the queue; the stored values need no clearing.
module sorted_array_priority_queue import sapq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  output logic                   s_tready_o,
  input  logic [DATA_W-1:0]      s_tdata_i,  // [31:0] value
  input  logic [CMD_W-1:0]       s_tuser_i,  // [0] command
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [OUT_TDATA_W-1:0] m_tdata_o,  // [31:0] removed_value, [37:32] entries_held
  output logic [STATUS_W-1:0]    m_tuser_o   // [1:0] status
);

  ctl_cmd_t            cmd;
  dp_sts_t             sts;
  logic [DATA_W-1:0]   out_value;
  logic [HELD_W-1:0]   out_held;

  sapq_controller u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_tvalid_i),
    .item_cmd_i   (s_tuser_i),
    .item_ready_o (s_tready_o),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  sapq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (s_tdata_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_tready_i),
    .out_valid_o  (m_tvalid_o),
    .out_value_o  (out_value),
    .out_status_o (m_tuser_o),
    .out_held_o   (out_held)
  );

  assign m_tdata_o = OUT_TDATA_W'({out_held, out_value});

endmodule

[design/sapq_checker.sv]
module sapq_checker import sapq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_tvalid_i,
  input logic                   s_tready_o,
  input logic                   m_tvalid_o,
  input logic                   m_tready_i,
  input logic [OUT_TDATA_W-1:0] m_tdata_o,
  input logic [STATUS_W-1:0]    m_tuser_o
);

  // A refused or empty item never carries a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && (m_tuser_o != STATUS_OK)) |-> (m_tdata_o[DATA_W-1:0] == '0))
    else $error("non-ok result carries a nonzero value");

  // A full refusal reports the queue at capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && (m_tuser_o == STATUS_FULL)) |->
      (m_tdata_o[DATA_W+HELD_W-1:DATA_W] == HELD_W'(CAPACITY)))
    else $error("full status with count below capacity");

  // An empty status reports no entries held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && (m_tuser_o == STATUS_EMPTY)) |->
      (m_tdata_o[DATA_W+HELD_W-1:DATA_W] == '0))
    else $error("empty status with entries held");

  // Items are handled one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> !s_tready_o)
    else $error("item accepted while the previous one is in progress");

  // A stalled result holds still until the receiver takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=>
      (m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o)))
    else $error("stalled result changed before it was taken");

endmodule

bind sorted_array_priority_queue sapq_checker #(
  .CAPACITY (CAPACITY)
) u_sapq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o)
);

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import sapq_pkg::*;

  localparam int unsigned CAPACITY     = CAPACITY_DEF;
  localparam int          RANDOM_ITEMS = 1750;
  localparam int          NUM_PHASES   = 4;
  localparam int          DRAIN_CYCLES = CAPACITY + 8;

  // Idle odds per phase: none, sender only, receiver only, both.
  localparam int SEND_IDLE [NUM_PHASES] = '{0, 83, 0, 37};
  localparam int RECV_STALL[NUM_PHASES] = '{0, 0, 83, 37};

  typedef struct packed {
    logic [DATA_W-1:0]   removed;
    logic [STATUS_W-1:0] status;
    logic [HELD_W-1:0]   held;
  } pq_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] value;
    logic              typed;
    pq_result_t        result;
  } stim_row_t;

  localparam int NUM_DIRECTED = 19;

  // Rows with typed set carry a result that follows directly from the sequence.
  localparam stim_row_t DIRECTED[NUM_DIRECTED] = '{
    '{CMD_REMOVE, 32'h0000_0000, 1'b1, '{32'h0000_0000, STATUS_EMPTY, 6'd0}},
    '{CMD_INSERT, 32'h7fff_ffff, 1'b1, '{32'h0000_0000, STATUS_OK,    6'd1}},
    '{CMD_INSERT, 32'h8000_0000, 1'b1, '{32'h0000_0000, STATUS_OK,    6'd2}},
    '{CMD_INSERT, 32'h0000_0000, 1'b1, '{32'h0000_0000, STATUS_OK,    6'd3}},
    '{CMD_INSERT, 32'hffff_ffff, 1'b1, '{32'h0000_0000, STATUS_OK,    6'd4}},
    '{CMD_INSERT, 32'h7fff_ffff, 1'b1, '{32'h0000_0000, STATUS_OK,    6'd5}},
    '{CMD_REMOVE, 32'hffff_ffff, 1'b1, '{32'h8000_0000, STATUS_OK,    6'd4}},
    '{CMD_REMOVE, 32'h0000_0000, 1'b1, '{32'hffff_ffff, STATUS_OK,    6'd3}},
    '{CMD_REMOVE, 32'haaaa_aaaa, 1'b1, '{32'h0000_0000, STATUS_OK,    6'd2}},
    '{CMD_REMOVE, 32'h5555_5555, 1'b1, '{32'h7fff_ffff, STATUS_OK,    6'd1}},
    '{CMD_REMOVE, 32'h0000_0000, 1'b1, '{32'h7fff_ffff, STATUS_OK,    6'd0}},
    '{CMD_REMOVE, 32'hffff_ffff, 1'b1, '{32'h0000_0000, STATUS_EMPTY, 6'd0}},
    '{CMD_INSERT, 32'h5555_5555, 1'b0, '0},
    '{CMD_INSERT, 32'haaaa_aaaa, 1'b0, '0},
    '{CMD_INSERT, 32'h5555_5555, 1'b0, '0},
    '{CMD_REMOVE, 32'h0000_0000, 1'b0, '0},
    '{CMD_REMOVE, 32'hffff_ffff, 1'b0, '0},
    '{CMD_REMOVE, 32'h0000_0000, 1'b0, '0},
    '{CMD_REMOVE, 32'haaaa_aaaa, 1'b0, '0}
  };

  logic                   clk_i      = 1'b0;
  logic                   rst_ni     = 1'b0;
  logic                   s_tvalid_i = 1'b0;
  logic                   s_tready_o;
  logic [DATA_W-1:0]      s_tdata_i  = '0;  // [31:0] value
  logic [CMD_W-1:0]       s_tuser_i  = CMD_INSERT;  // [0] command
  logic                   m_tvalid_o;
  logic                   m_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata_o;  // [31:0] removed_value, [37:32] entries_held
  logic [STATUS_W-1:0]    m_tuser_o;  // [1:0] status

  sorted_array_priority_queue #(.CAPACITY(CAPACITY)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  always #4 clk_i = ~clk_i;

  // Mirror of the live entries, kept in ascending order.
  logic signed [DATA_W-1:0] queue_mirror[$];
  pq_result_t               pending_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int mismatches     = 0;
  int inserts_done   = 0;
  int removes_done   = 0;
  int full_refusals  = 0;
  int empty_removes  = 0;
  int peak_held      = 0;

  function automatic pq_result_t predict_queue_op(input logic [CMD_W-1:0] cmd,
                                                  input logic signed [DATA_W-1:0] val);
    pq_result_t r;
    int         pos;
    r = '0;
    if (cmd == CMD_INSERT) begin
      if (queue_mirror.size() >= CAPACITY) begin
        r.status = STATUS_FULL;
        full_refusals++;
      end else begin
        // The new value goes after every stored value that is not larger.
        pos = 0;
        while (pos < queue_mirror.size() && queue_mirror[pos] <= val) pos++;
        queue_mirror.insert(pos, val);
        inserts_done++;
      end
    end else begin
      if (queue_mirror.size() == 0) begin
        r.status = STATUS_EMPTY;
        empty_removes++;
      end else begin
        r.removed = queue_mirror.pop_front();
        removes_done++;
      end
    end
    if (queue_mirror.size() > peak_held) peak_held = queue_mirror.size();
    r.held = HELD_W'(queue_mirror.size());
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 4))
      0: v = DATA_W'(int'($urandom_range(0, 20)) - 10);
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      2: v = DATA_W'(int'($urandom_range(0, 4)) - 2);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic note_mismatch(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    $display("%0t ns: mismatch in %s: expected %h, got %h", $time, field, want, got);
    mismatches++;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val,
                           input logic typed, input pq_result_t typed_result);
    pq_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= val;
    s_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_tready_o);
    predicted = predict_queue_op(cmd, val);
    pending_results.push_back(typed ? typed_result : predicted);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  always @(negedge clk_i) begin
    m_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    pq_result_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected item", '0, m_tdata_o[DATA_W-1:0]);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata_o[DATA_W-1:0] !== want.removed)
          note_mismatch("removed_value", want.removed, m_tdata_o[DATA_W-1:0]);
        if (m_tuser_o !== want.status)
          note_mismatch("status", DATA_W'(want.status), DATA_W'(m_tuser_o));
        if (m_tdata_o[DATA_W+HELD_W-1:DATA_W] !== want.held)
          note_mismatch("entries_held", DATA_W'(want.held),
                        DATA_W'(m_tdata_o[DATA_W+HELD_W-1:DATA_W]));
      end
    end
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int phase;
    int target;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_item(DIRECTED[i].cmd, DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].result);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      send_idle_pct  = SEND_IDLE[phase];
      recv_stall_pct = RECV_STALL[phase];
      wait_drained();
      target = items_sent + RANDOM_ITEMS / NUM_PHASES;
      while (items_sent < target) begin
        case ($urandom_range(0, 3))
          0: begin
            // Fill to the top, then push a few that must be refused.
            while (queue_mirror.size() < CAPACITY)
              send_item(CMD_INSERT, pick_value(), 1'b0, '0);
            repeat ($urandom_range(1, 3)) send_item(CMD_INSERT, pick_value(), 1'b0, '0);
          end
          1: begin
            while (queue_mirror.size() > 0) send_item(CMD_REMOVE, $urandom, 1'b0, '0);
            repeat ($urandom_range(1, 2)) send_item(CMD_REMOVE, $urandom, 1'b0, '0);
          end
          2: begin
            repeat (20) begin
              if ($urandom_range(0, 1) == 0) send_item(CMD_INSERT, pick_value(), 1'b0, '0);
              else send_item(CMD_REMOVE, $urandom, 1'b0, '0);
            end
          end
          default: begin
            // Many equal keys exercise the ordering of ties.
            repeat (8) send_item(CMD_INSERT, DATA_W'(int'($urandom_range(0, 4)) - 2), 1'b0, '0);
            repeat (4) send_item(CMD_REMOVE, $urandom, 1'b0, '0);
          end
        endcase
      end
    end

    s_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d items: %0d inserts, %0d removals, %0d inserts refused full,",
             items_sent, inserts_done, removes_done, full_refusals);
    $display("%0d empty removals; peak occupancy %0d of %0d entries across four %s; %0d mismatches.",
             empty_removes, peak_held, CAPACITY, "stall mixes", mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/sapq_pkg.sv
design/sapq_ram.sv
design/sapq_controller.sv
design/sapq_datapath.sv
design/sorted_array_priority_queue.sv
design/sapq_checker.sv
bench/tb_top.sv
